// ----- design/edf_pkg.sv -----
`default_nettype none

package edf_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int COEF_WIDTH     = 21;
  localparam int COORD_FRAC     = 8;
  localparam int THRESH_WIDTH   = 24;
  localparam int ROW_WIDTH      = 63;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 63;

  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(512);

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_E_TOP    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_E_MID    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_E_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESH   = 2'd3;

endpackage

`default_nettype wire

// ----- design/edf_in_if.sv -----
`default_nettype none

interface edf_in_if #(
  parameter int COORD_WIDTH = edf_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;

  modport source (
    output valid, first_x, first_y, second_x, second_y,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, second_x, second_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/edf_out_if.sv -----
`default_nettype none

interface edf_out_if #(
  parameter int COORD_WIDTH = edf_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          keep;
  logic signed [COORD_WIDTH-1:0] out_first_x;
  logic signed [COORD_WIDTH-1:0] out_first_y;
  logic signed [COORD_WIDTH-1:0] out_second_x;
  logic signed [COORD_WIDTH-1:0] out_second_y;

  modport source (
    output valid, keep, out_first_x, out_first_y, out_second_x, out_second_y,
    input  ready
  );

  modport sink (
    input  valid, keep, out_first_x, out_first_y, out_second_x, out_second_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/edf_line.sv -----
`default_nettype none

// epipolar line (a, b, c) = E * (x1, y1, 1): products, then row sums
module edf_line #(
  parameter int  COORD_WIDTH = edf_pkg::COORD_WIDTH,
  parameter int  COEF_WIDTH  = edf_pkg::COEF_WIDTH,
  localparam int PtsW        = 4 * COORD_WIDTH,
  localparam int LineW       = COEF_WIDTH + COORD_WIDTH + 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [edf_pkg::ROW_WIDTH-1:0] e_top_i,
  input  wire logic [edf_pkg::ROW_WIDTH-1:0] e_mid_i,
  input  wire logic [edf_pkg::ROW_WIDTH-1:0] e_bottom_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [PtsW-1:0]               pts_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [PtsW-1:0]               pts_o,
  output      logic signed [LineW-1:0]       line_a_o,
  output      logic signed [LineW-1:0]       line_b_o,
  output      logic signed [LineW-1:0]       line_c_o
);

  localparam int ProdW = COEF_WIDTH + COORD_WIDTH;

  logic [edf_pkg::ROW_WIDTH-1:0]  rows [3];
  logic signed [COEF_WIDTH-1:0]   coef [3][3];
  logic signed [COORD_WIDTH-1:0]  x1;
  logic signed [COORD_WIDTH-1:0]  y1;

  logic                           v1_q, v2_q;
  logic                           rdy1, rdy2;
  logic signed [ProdW-1:0]        prod_q [3][2];
  logic signed [COEF_WIDTH-1:0]   cc_q [3];
  logic [PtsW-1:0]                pts1_q, pts2_q;
  logic signed [LineW-1:0]        line_q [3];

  assign rows[0] = e_top_i;
  assign rows[1] = e_mid_i;
  assign rows[2] = e_bottom_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        coef[r][j] = $signed(rows[r][j*COEF_WIDTH +: COEF_WIDTH]);
      end
    end
  end

  assign x1 = $signed(pts_i[0 +: COORD_WIDTH]);
  assign y1 = $signed(pts_i[COORD_WIDTH +: COORD_WIDTH]);

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= coef[r][0] * x1;
        prod_q[r][1] <= coef[r][1] * y1;
        cc_q[r]      <= coef[r][2];
      end
      pts1_q <= pts_i;
    end
    if (rdy2) begin
      for (int r = 0; r < 3; r++) begin
        line_q[r] <= LineW'(prod_q[r][0]) + LineW'(prod_q[r][1])
                   + (LineW'(cc_q[r]) <<< edf_pkg::COORD_FRAC);
      end
      pts2_q <= pts1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign pts_o       = pts2_q;
  assign line_a_o    = line_q[0];
  assign line_b_o    = line_q[1];
  assign line_c_o    = line_q[2];

endmodule

`default_nettype wire

// ----- design/edf_quad.sv -----
`default_nettype none

// residual s = a*x2 + b*y2 + c and norm a^2 + b^2 from split half-width products
module edf_quad #(
  parameter int  COORD_WIDTH = edf_pkg::COORD_WIDTH,
  parameter int  COEF_WIDTH  = edf_pkg::COEF_WIDTH,
  localparam int PtsW        = 4 * COORD_WIDTH,
  localparam int LineW       = COEF_WIDTH + COORD_WIDTH + 2,
  localparam int SW          = LineW + COORD_WIDTH + 2,
  localparam int QW          = 2 * LineW
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic [PtsW-1:0]         pts_i,
  input  wire logic signed [LineW-1:0] line_a_i,
  input  wire logic signed [LineW-1:0] line_b_i,
  input  wire logic signed [LineW-1:0] line_c_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic [PtsW-1:0]         pts_o,
  output      logic [SW-1:0]           sabs_o,
  output      logic [QW-1:0]           qsum_o
);

  localparam int LoW  = (LineW + 1) / 2;
  localparam int HiW  = LineW - LoW;
  localparam int AxW  = LineW + COORD_WIDTH;
  localparam int CcW  = LineW + edf_pkg::COORD_FRAC;
  localparam int A2W  = 2 * LineW - 1;

  logic signed [LoW:0]             a_lo, b_lo;
  logic signed [HiW-1:0]           a_hi, b_hi;
  logic signed [COORD_WIDTH-1:0]   x2, y2;

  logic                            v3_q, v4_q, v5_q, v6_q;
  logic                            rdy3, rdy4, rdy5, rdy6;
  logic [PtsW-1:0]                 pts3_q, pts4_q, pts5_q, pts6_q;

  // stage 3 partial products
  logic signed [LoW+COORD_WIDTH:0]   alx_q, bly_q;
  logic signed [HiW+COORD_WIDTH-1:0] ahx_q, bhy_q;
  logic [2*LoW-1:0]                  all_q, bll_q;
  logic signed [LoW+HiW:0]           alh_q, blh_q;
  logic signed [2*HiW-1:0]           ahh_q, bhh_q;
  logic signed [LineW-1:0]           c3_q;

  // stage 4 recombined terms
  logic signed [AxW-1:0]           ax_q, by_q;
  logic signed [CcW-1:0]           cc4_q;
  logic [A2W-1:0]                  a2_q, b2_q;

  // stage 5 sums, stage 6 magnitude
  logic signed [SW-1:0]            s_q;
  logic [QW-1:0]                   q5_q, q6_q;
  logic [SW-1:0]                   sabs_q;

  assign a_lo = $signed({1'b0, line_a_i[LoW-1:0]});
  assign b_lo = $signed({1'b0, line_b_i[LoW-1:0]});
  assign a_hi = line_a_i[LineW-1:LoW];
  assign b_hi = line_b_i[LineW-1:LoW];
  assign x2   = $signed(pts_i[2*COORD_WIDTH +: COORD_WIDTH]);
  assign y2   = $signed(pts_i[3*COORD_WIDTH +: COORD_WIDTH]);

  assign rdy6       = !v6_q || out_ready_i;
  assign rdy5       = !v5_q || rdy6;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign in_ready_o = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= in_valid_i;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      alx_q  <= a_lo * x2;
      ahx_q  <= a_hi * x2;
      bly_q  <= b_lo * y2;
      bhy_q  <= b_hi * y2;
      all_q  <= line_a_i[LoW-1:0] * line_a_i[LoW-1:0];
      bll_q  <= line_b_i[LoW-1:0] * line_b_i[LoW-1:0];
      alh_q  <= a_lo * a_hi;
      blh_q  <= b_lo * b_hi;
      ahh_q  <= a_hi * a_hi;
      bhh_q  <= b_hi * b_hi;
      c3_q   <= line_c_i;
      pts3_q <= pts_i;
    end
    if (rdy4) begin
      ax_q   <= (AxW'(ahx_q) <<< LoW) + AxW'(alx_q);
      by_q   <= (AxW'(bhy_q) <<< LoW) + AxW'(bly_q);
      cc4_q  <= CcW'(c3_q) <<< edf_pkg::COORD_FRAC;
      // cross term counted twice, hence one extra bit of shift
      a2_q   <= (A2W'(ahh_q) << (2 * LoW)) + (A2W'(alh_q) << (LoW + 1)) + A2W'(all_q);
      b2_q   <= (A2W'(bhh_q) << (2 * LoW)) + (A2W'(blh_q) << (LoW + 1)) + A2W'(bll_q);
      pts4_q <= pts3_q;
    end
    if (rdy5) begin
      s_q    <= SW'(ax_q) + SW'(by_q) + SW'(cc4_q);
      q5_q   <= QW'(a2_q) + QW'(b2_q);
      pts5_q <= pts4_q;
    end
    if (rdy6) begin
      // most negative residual maps to 2^(SW-1), still exact as unsigned
      sabs_q <= s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
      q6_q   <= q5_q;
      pts6_q <= pts5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign pts_o       = pts6_q;
  assign sabs_o      = sabs_q;
  assign qsum_o      = q6_q;

endmodule

`default_nettype wire

// ----- design/edf_cmp.sv -----
`default_nettype none

// s^2 against T^2 * (a^2 + b^2): limb products, two add levels, compare
module edf_cmp #(
  parameter int  COORD_WIDTH = edf_pkg::COORD_WIDTH,
  parameter int  COEF_WIDTH  = edf_pkg::COEF_WIDTH,
  localparam int PtsW        = 4 * COORD_WIDTH,
  localparam int LineW       = COEF_WIDTH + COORD_WIDTH + 2,
  localparam int SW          = LineW + COORD_WIDTH + 2,
  localparam int QW          = 2 * LineW
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [edf_pkg::THRESH_WIDTH-1:0] thr_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic [PtsW-1:0]                  pts_i,
  input  wire logic [SW-1:0]                    sabs_i,
  input  wire logic [QW-1:0]                    qsum_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [PtsW-1:0]                  pts_o,
  output      logic                             keep_o
);

  localparam int TW   = edf_pkg::THRESH_WIDTH;
  localparam int SL   = (SW + 2) / 3;
  localparam int QL   = (QW + 3) / 4;
  localparam int LW   = 6 * SL;
  localparam int RW   = 4 * QL + 2 * TW;
  localparam int CmpW = (LW > RW) ? LW : RW;

  logic [2*TW-1:0]        thr_sq_q;
  logic [3*SL-1:0]        sext;
  logic [4*QL-1:0]        qext;
  logic [SL-1:0]          sl [3];
  logic [QL-1:0]          ql [4];
  logic [TW-1:0]          tl [2];

  logic                   v7_q, v8_q, v9_q, v10_q;
  logic                   rdy7, rdy8, rdy9, rdy10;
  logic [PtsW-1:0]        pts7_q, pts8_q, pts9_q, pts10_q;

  logic [2*SL-1:0]        ps_q [6];
  logic [QL+TW-1:0]       pq_q [4][2];
  logic [LW-1:0]          lhs_a_q, lhs_b_q, lhs_q;
  logic [RW-1:0]          rhs_a_d, rhs_b_d, rhs_a_q, rhs_b_q, rhs_q;
  logic                   keep_q;

  // the user must change the threshold only while the pipe is empty; this block does not enforce it
  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_i * thr_i;
  end

  assign sext = (3 * SL)'(sabs_i);
  assign qext = (4 * QL)'(qsum_i);

  always_comb begin
    for (int k = 0; k < 3; k++) sl[k] = sext[k*SL +: SL];
    for (int k = 0; k < 4; k++) ql[k] = qext[k*QL +: QL];
    for (int k = 0; k < 2; k++) tl[k] = thr_sq_q[k*TW +: TW];
  end

  always_comb begin
    rhs_a_d = '0;
    rhs_b_d = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        rhs_a_d = rhs_a_d + (RW'(pq_q[i][j]) << (i * QL + j * TW));
        rhs_b_d = rhs_b_d + (RW'(pq_q[i+2][j]) << ((i + 2) * QL + j * TW));
      end
    end
  end

  assign rdy10      = !v10_q || out_ready_i;
  assign rdy9       = !v9_q || rdy10;
  assign rdy8       = !v8_q || rdy9;
  assign rdy7       = !v7_q || rdy8;
  assign in_ready_o = rdy7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      if (rdy7)  v7_q  <= in_valid_i;
      if (rdy8)  v8_q  <= v7_q;
      if (rdy9)  v9_q  <= v8_q;
      if (rdy10) v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy7) begin
      ps_q[0] <= sl[0] * sl[0];
      ps_q[1] <= sl[0] * sl[1];
      ps_q[2] <= sl[1] * sl[1];
      ps_q[3] <= sl[0] * sl[2];
      ps_q[4] <= sl[1] * sl[2];
      ps_q[5] <= sl[2] * sl[2];
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          pq_q[i][j] <= ql[i] * tl[j];
        end
      end
      pts7_q <= pts_i;
    end
    if (rdy8) begin
      lhs_a_q <= LW'(ps_q[0]) + (LW'(ps_q[1]) << (SL + 1)) + (LW'(ps_q[2]) << (2 * SL));
      lhs_b_q <= (LW'(ps_q[3]) << (2 * SL + 1)) + (LW'(ps_q[4]) << (3 * SL + 1))
               + (LW'(ps_q[5]) << (4 * SL));
      rhs_a_q <= rhs_a_d;
      rhs_b_q <= rhs_b_d;
      pts8_q  <= pts7_q;
    end
    if (rdy9) begin
      lhs_q  <= lhs_a_q + lhs_b_q;
      rhs_q  <= rhs_a_q + rhs_b_q;
      pts9_q <= pts8_q;
    end
    if (rdy10) begin
      keep_q  <= CmpW'(lhs_q) < CmpW'(rhs_q);
      pts10_q <= pts9_q;
    end
  end

  assign out_valid_o = v10_q;
  assign pts_o       = pts10_q;
  assign keep_o      = keep_q;

  // degenerate line or zero threshold never keeps
  a_zero_rhs_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v9_q && rdy10 && rhs_q == '0) |=> !keep_q)
    else $error("pair kept with zero right-hand side");

  // a residual of zero keeps exactly when the right-hand side is positive
  a_zero_lhs_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v9_q && rdy10 && lhs_q == '0) |=> keep_q == $past(rhs_q != '0))
    else $error("zero residual gave wrong keep");

  // a blocked final sum stage holds its operands
  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v9_q && !rdy10) |=> ($stable(lhs_q) && $stable(rhs_q) && v9_q))
    else $error("stalled sum stage changed");

endmodule

`default_nettype wire

// ----- design/epipolar_distance_filter_unit.sv -----
`default_nettype none

// channel  | dir | handshake           | payload
// in_i     | in  | valid/ready         | first_x, first_y, second_x, second_y
// out_o    | out | valid/ready         | keep, out_first_x/y, out_second_x/y
// cfg      | in  | cfg_we_i, no stall  | cfg_idx_i, cfg_data_i
//
// one pair per cycle unless the output stalls; each result transfer follows its input transfer
// the ten register stages are set by the split multiplies: line products, residual
// and norm half-width products, and the final limb products of s^2 and T^2*(a^2+b^2)
// every stage has its own valid bit and loads when it is empty or its successor moves,
// so bubbles close up and a stalled output holds without loss or repeat
// reset clears all valid bits, the E rows to zero and the threshold to 2.0 pixels
module epipolar_distance_filter_unit #(
  parameter int COORD_WIDTH = edf_pkg::COORD_WIDTH,
  parameter int COEF_WIDTH  = edf_pkg::COEF_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  edf_in_if.sink                                  in_i,
  edf_out_if.source                               out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [edf_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  wire logic [edf_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);

  localparam int PtsW  = 4 * COORD_WIDTH;
  localparam int LineW = COEF_WIDTH + COORD_WIDTH + 2;
  localparam int SW    = LineW + COORD_WIDTH + 2;
  localparam int QW    = 2 * LineW;

  logic [edf_pkg::ROW_WIDTH-1:0]    e_top_q, e_mid_q, e_bottom_q;
  logic [edf_pkg::THRESH_WIDTH-1:0] thr_q;

  logic [PtsW-1:0]          pts_in, pts_l, pts_q6, pts_out;
  logic                     l_valid, l_ready, q_valid, q_ready;
  logic signed [LineW-1:0]  line_a, line_b, line_c;
  logic [SW-1:0]            sabs;
  logic [QW-1:0]            qsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_top_q    <= '0;
      e_mid_q    <= '0;
      e_bottom_q <= '0;
      thr_q      <= edf_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        edf_pkg::CFG_E_TOP:    e_top_q    <= cfg_data_i[edf_pkg::ROW_WIDTH-1:0];
        edf_pkg::CFG_E_MID:    e_mid_q    <= cfg_data_i[edf_pkg::ROW_WIDTH-1:0];
        edf_pkg::CFG_E_BOTTOM: e_bottom_q <= cfg_data_i[edf_pkg::ROW_WIDTH-1:0];
        edf_pkg::CFG_THRESH:   thr_q      <= cfg_data_i[edf_pkg::THRESH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign pts_in = {in_i.second_y, in_i.second_x, in_i.first_y, in_i.first_x};

  edf_line #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .e_top_i     (e_top_q),
    .e_mid_i     (e_mid_q),
    .e_bottom_i  (e_bottom_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .pts_i       (pts_in),
    .out_valid_o (l_valid),
    .out_ready_i (l_ready),
    .pts_o       (pts_l),
    .line_a_o    (line_a),
    .line_b_o    (line_b),
    .line_c_o    (line_c)
  );

  edf_quad #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_quad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (l_valid),
    .in_ready_o  (l_ready),
    .pts_i       (pts_l),
    .line_a_i    (line_a),
    .line_b_i    (line_b),
    .line_c_i    (line_c),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .pts_o       (pts_q6),
    .sabs_o      (sabs),
    .qsum_o      (qsum)
  );

  edf_cmp #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .pts_i       (pts_q6),
    .sabs_i      (sabs),
    .qsum_i      (qsum),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .pts_o       (pts_out),
    .keep_o      (out_o.keep)
  );

  assign out_o.out_first_x  = pts_out[0 +: COORD_WIDTH];
  assign out_o.out_first_y  = pts_out[COORD_WIDTH +: COORD_WIDTH];
  assign out_o.out_second_x = pts_out[2*COORD_WIDTH +: COORD_WIDTH];
  assign out_o.out_second_y = pts_out[3*COORD_WIDTH +: COORD_WIDTH];

endmodule

`default_nettype wire

// ----- tb/edf_pair_checker.sv -----
`timescale 1ns / 100ps

module edf_pair_checker
  import edf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  edf_in_if                         in_mon_i,
  edf_out_if                        out_mon_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);

  // wide enough for s^2 and T^2*(a^2+b^2) without any wrap
  localparam int WIDE = 192;
  typedef logic signed [WIDE-1:0] wide_t;

  typedef struct packed {
    logic                   keep;
    logic [COORD_WIDTH-1:0] first_x;
    logic [COORD_WIDTH-1:0] first_y;
    logic [COORD_WIDTH-1:0] second_x;
    logic [COORD_WIDTH-1:0] second_y;
  } pair_verdict_t;

  logic [ROW_WIDTH-1:0]    e_row [3];
  logic [THRESH_WIDTH-1:0] thresh = THRESH_RESET;
  pair_verdict_t           expected_pairs [$];
  pair_verdict_t           want;
  pair_verdict_t           got;
  int                      mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic wide_t e_coef(input logic [ROW_WIDTH-1:0] row, input int col);
    logic signed [COEF_WIDTH-1:0] k;
    wide_t                        w;
    k = row[col*COEF_WIDTH +: COEF_WIDTH];
    w = k;
    return w;
  endfunction

  function automatic logic within_epipolar_band(
    input logic signed [COORD_WIDTH-1:0] x1,
    input logic signed [COORD_WIDTH-1:0] y1,
    input logic signed [COORD_WIDTH-1:0] x2,
    input logic signed [COORD_WIDTH-1:0] y2
  );
    wide_t wx1, wy1, wx2, wy2, one, a, b, c, resid, lhs, rhs, t;
    wx1 = x1;
    wy1 = y1;
    wx2 = x2;
    wy2 = y2;
    one = '0;
    one[COORD_FRAC] = 1'b1;
    a = e_coef(e_row[0], 0) * wx1 + e_coef(e_row[0], 1) * wy1 + e_coef(e_row[0], 2) * one;
    b = e_coef(e_row[1], 0) * wx1 + e_coef(e_row[1], 1) * wy1 + e_coef(e_row[1], 2) * one;
    c = e_coef(e_row[2], 0) * wx1 + e_coef(e_row[2], 1) * wy1 + e_coef(e_row[2], 2) * one;
    resid = a * wx2 + b * wy2 + c * one;
    lhs = resid * resid;
    t = thresh;
    rhs = t * t * (a * a + b * b);
    // degenerate line gives rhs of zero, so it never keeps
    return lhs < rhs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_row[0] = '0;
      e_row[1] = '0;
      e_row[2] = '0;
      thresh = THRESH_RESET;
      expected_pairs.delete();
    end else begin
      // input transfer sees the registers as they were before this edge
      if (in_mon_i.valid && in_mon_i.ready) begin
        want.keep = within_epipolar_band(in_mon_i.first_x, in_mon_i.first_y,
                                         in_mon_i.second_x, in_mon_i.second_y);
        want.first_x  = in_mon_i.first_x;
        want.first_y  = in_mon_i.first_y;
        want.second_x = in_mon_i.second_x;
        want.second_y = in_mon_i.second_y;
        expected_pairs.insert(expected_pairs.size(), want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_E_TOP:    e_row[0] = cfg_data_i[ROW_WIDTH-1:0];
          CFG_E_MID:    e_row[1] = cfg_data_i[ROW_WIDTH-1:0];
          CFG_E_BOTTOM: e_row[2] = cfg_data_i[ROW_WIDTH-1:0];
          CFG_THRESH:   thresh = cfg_data_i[THRESH_WIDTH-1:0];
          default: ;
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.keep     = out_mon_i.keep;
        got.first_x  = out_mon_i.out_first_x;
        got.first_y  = out_mon_i.out_first_y;
        got.second_x = out_mon_i.out_second_x;
        got.second_y = out_mon_i.out_second_y;
        if (expected_pairs.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result transfer with nothing expected: keep %0b %h %h %h %h",
                     $time, got.keep, got.first_x, got.first_y, got.second_x, got.second_y);
          end
          mismatches++;
        end else begin
          want = expected_pairs.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: pair mismatch, expected keep %0b %h %h %h %h", $time,
                       want.keep, want.first_x, want.first_y, want.second_x, want.second_y);
              $display("%0t:                  got keep %0b %h %h %h %h", $time,
                       got.keep, got.first_x, got.first_y, got.second_x, got.second_y);
            end
            mismatches++;
          end
        end
      end
    end
    pending_o = expected_pairs.size();
  end

endmodule

// ----- tb/tb_epipolar_distance_filter_unit.sv -----
`timescale 1ns / 100ps

module tb_epipolar_distance_filter_unit;
  import edf_pkg::*;

  localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam int K_MAX = (1 << (COEF_WIDTH - 1)) - 1;
  localparam int K_MIN = -(1 << (COEF_WIDTH - 1));
  localparam int PHASES = 10;
  localparam int PAIRS_PER_PHASE = 125;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int mismatches;
  int pending;

  edf_in_if  in_if ();
  edf_out_if out_if ();

  epipolar_distance_filter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  edf_pair_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_if),
    .out_mon_i        (out_if),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when one is requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (hold_len > 0) begin
        out_if.ready <= 1'b0;
        hold_len--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [ROW_WIDTH-1:0] pack_row(input int k0, input int k1, input int k2);
    return {COEF_WIDTH'(k2), COEF_WIDTH'(k1), COEF_WIDTH'(k0)};
  endfunction

  task automatic load_config(input logic [ROW_WIDTH-1:0] top, input logic [ROW_WIDTH-1:0] mid,
                             input logic [ROW_WIDTH-1:0] bottom,
                             input logic [THRESH_WIDTH-1:0] thr);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_E_TOP;
    cfg_data <= top;
    @(negedge clk_i);
    cfg_idx  <= CFG_E_MID;
    cfg_data <= mid;
    @(negedge clk_i);
    cfg_idx  <= CFG_E_BOTTOM;
    cfg_data <= bottom;
    @(negedge clk_i);
    cfg_idx  <= CFG_THRESH;
    cfg_data <= CFG_DATA_WIDTH'(thr);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // pure translation (u, -t, 0): distance is |u*dx - t*dy| / sqrt(u^2 + t^2)
  task automatic load_translation(input int u, input int t, input logic [THRESH_WIDTH-1:0] thr);
    load_config(pack_row(0, 0, u), pack_row(0, 0, -t), pack_row(-u, t, 0), thr);
  endtask

  task automatic send_pair(input logic [COORD_WIDTH-1:0] x1, input logic [COORD_WIDTH-1:0] y1,
                           input logic [COORD_WIDTH-1:0] x2, input logic [COORD_WIDTH-1:0] y2);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.first_x  <= x1;
    in_if.first_y  <= y1;
    in_if.second_x <= x2;
    in_if.second_y <= y2;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // pair near the epipolar line of a translation setup
  task automatic send_near_pair(input int span);
    int x1, y1, dx, dy;
    x1 = int'($urandom_range(8388607)) - 4194304;
    y1 = int'($urandom_range(8388607)) - 4194304;
    dx = int'($urandom_range(2 * span)) - span;
    dy = int'($urandom_range(2 * span)) - span;
    send_pair(COORD_WIDTH'(x1), COORD_WIDTH'(y1), COORD_WIDTH'(x1 + dx), COORD_WIDTH'(y1 + dy));
  endtask

  task automatic send_noise_pair();
    send_pair(COORD_WIDTH'($urandom()), COORD_WIDTH'($urandom()),
              COORD_WIDTH'($urandom()), COORD_WIDTH'($urandom()));
  endtask

  // drain the pipeline before touching the registers
  task automatic settle();
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk_i);
  endtask

  initial begin
    int                      ph;
    int                      u;
    int                      t;
    int                      span;
    logic [THRESH_WIDTH-1:0] thr;
    logic                    noise_phase;

    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_E_TOP;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.first_x  = '0;
    in_if.first_y  = '0;
    in_if.second_x = '0;
    in_if.second_y = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset: E is zero, so every line is degenerate
    send_pair(C_MAX, C_MAX, C_MAX, C_MAX);
    send_pair(C_MIN, C_MIN, C_MIN, C_MIN);
    send_pair('0, '0, '0, '0);
    settle();

    // horizontal offset only, threshold 2.0 is exclusive
    load_translation(1, 0, 24'd512);
    send_pair(24'd1000, C_MIN, 24'd1000, C_MAX);
    send_pair(24'd1000, 24'd5, 24'd1511, 24'd9);
    send_pair(24'd1000, 24'd5, 24'd1512, 24'd9);
    send_pair(24'd1000, 24'd5, 24'd488, 24'd9);
    send_pair(24'd1000, 24'd5, 24'd489, 24'd9);
    settle();

    // zero threshold keeps nothing, not even a point on the line
    load_translation(1, 0, 24'd0);
    send_pair(24'd1000, 24'd5, 24'd1000, 24'd5);
    settle();

    // extreme coefficients and coordinates stress the full product width
    load_config(pack_row(K_MIN, K_MIN, K_MIN), pack_row(K_MIN, K_MIN, K_MIN),
                pack_row(K_MIN, K_MIN, K_MIN), 24'hFFFFFF);
    send_pair(C_MAX, C_MIN, C_MAX, C_MIN);
    send_pair(C_MIN, C_MAX, C_MIN, C_MAX);
    send_pair(C_MAX, C_MAX, C_MAX, C_MAX);
    send_pair(C_MIN, C_MIN, C_MIN, C_MIN);
    settle();
    load_config(pack_row(K_MAX, K_MAX, K_MAX), pack_row(K_MAX, K_MAX, K_MAX),
                pack_row(K_MAX, K_MAX, K_MAX), 24'd1);
    send_pair(C_MAX, C_MIN, C_MAX, C_MIN);
    send_pair(C_MIN, C_MAX, C_MIN, C_MAX);
    send_pair(C_MAX, C_MAX, C_MAX, C_MAX);
    send_pair(C_MIN, C_MAX, C_MAX, C_MIN);
    settle();

    // vertical offset only
    load_translation(0, K_MAX, 24'd512);
    send_pair(C_MIN, C_MIN, 24'd5, C_MIN);
    send_pair('0, C_MAX, C_MAX, 24'h7FFDA7);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      noise_phase = (ph == 7 || ph == 9);
      if (noise_phase) begin
        thr = (ph == 9) ? 24'hFFFFFF : THRESH_WIDTH'($urandom());
        load_config(ROW_WIDTH'({$urandom(), $urandom()}), ROW_WIDTH'({$urandom(), $urandom()}),
                    ROW_WIDTH'({$urandom(), $urandom()}), thr);
      end else begin
        u = int'($urandom_range(2 * K_MAX)) - K_MAX;
        t = int'($urandom_range(2 * K_MAX)) - K_MAX;
        if (ph == 2) t = 0;
        if (ph == 6) u = 0;
        if (ph == 3) thr = '0;
        else if (ph == 5) thr = 24'hFFFFFF;
        else thr = THRESH_WIDTH'($urandom_range(4096, 1));
        load_translation(u, t, thr);
      end
      span = 2 * int'(thr) + 16;
      if (span > (1 << 21)) span = 1 << 21;
      if (ph == 4) begin
        // long output hold-off while the sender keeps offering pairs
        @(posedge clk_i);
        hold_len = 300;
        @(negedge clk_i);
      end
      repeat (PAIRS_PER_PHASE) begin
        if (!noise_phase && $urandom_range(9) < 8) send_near_pair(span);
        else send_noise_pair();
      end
    end

    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
